/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_PROP(lbl, !(cond), msg)

`endif

/* rtl/cbd_pkg.sv */
`default_nettype none

package cbd_pkg;

  typedef enum logic [3:0] {
    PH_LEAD    = 4'd0,
    PH_DIGITS  = 4'd1,
    PH_TAIL    = 4'd2,
    PH_TAIL_CR = 4'd3,
    PH_DATA    = 4'd4,
    PH_SKIP2   = 4'd5,
    PH_SKIP1   = 4'd6,
    PH_DONE    = 4'd7
  } phase_e;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_TERMINAL  = 2'd1;
  localparam logic [1:0] KIND_MALFORMED = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic [1:0] kind;
  } cbd_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      h.ok  = 1'b1;
      h.val = b[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

/* rtl/cbd_parser.sv */
`default_nettype none

module cbd_parser
  import cbd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output cbd_result_t      res_o
);

`include "assert_macros.svh"

  phase_e                   phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]   remaining_q, remaining_d;
  logic                     digit_seen_q, digit_seen_d;
  hex_digit_t               hex;
  logic [COUNT_WIDTH-1:0]   acc_size;
  phase_e                   other_phase;

  assign hex         = hex_decode(byte_i);
  assign other_phase = (byte_i == CH_CR) ? PH_TAIL_CR : PH_TAIL;

  // saturate once the top nibble is occupied
  always_comb begin
    if (remaining_q[COUNT_WIDTH-1 -: 4] != 4'd0) begin
      acc_size = '1;
    end else begin
      acc_size = {remaining_q[COUNT_WIDTH-5:0], hex.val};
    end
  end

  always_comb begin
    phase_d      = phase_q;
    remaining_d  = remaining_q;
    digit_seen_d = digit_seen_q;
    if (step_i) begin
      unique case (phase_q)
        PH_TAIL_CR: begin
          if (byte_i == CH_LF) begin
            if (!digit_seen_q || remaining_q == '0) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = PH_DATA;
            end
          end else begin
            phase_d = other_phase;
          end
        end
        PH_LEAD: begin
          if (byte_i == CH_SPACE || byte_i == CH_TAB) begin
            phase_d = PH_LEAD;
          end else if (hex.ok) begin
            digit_seen_d = 1'b1;
            remaining_d  = acc_size;
            phase_d      = PH_DIGITS;
          end else begin
            phase_d = other_phase;
          end
        end
        PH_DIGITS: begin
          if (hex.ok) begin
            remaining_d = acc_size;
          end else begin
            phase_d = other_phase;
          end
        end
        PH_TAIL: begin
          if (byte_i == CH_CR) begin
            phase_d = PH_TAIL_CR;
          end
        end
        PH_DATA: begin
          remaining_d = remaining_q - 1'b1;
          if (remaining_d == '0) begin
            phase_d = PH_SKIP2;
          end
        end
        PH_SKIP2: begin
          phase_d = PH_SKIP1;
        end
        PH_SKIP1: begin
          phase_d      = PH_LEAD;
          remaining_d  = '0;
          digit_seen_d = 1'b0;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_comb begin
    res_o.vld  = 1'b0;
    res_o.data = 8'd0;
    res_o.kind = KIND_DATA;
    if (step_i) begin
      unique case (phase_q)
        PH_TAIL_CR: begin
          if (byte_i == CH_LF && !digit_seen_q) begin
            res_o.vld  = 1'b1;
            res_o.kind = KIND_MALFORMED;
          end else if (byte_i == CH_LF && remaining_q == '0) begin
            res_o.vld  = 1'b1;
            res_o.kind = KIND_TERMINAL;
          end
        end
        PH_DATA: begin
          res_o.vld  = 1'b1;
          res_o.data = byte_i;
        end
        default: begin
          res_o.vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      remaining_q  <= '0;
      digit_seen_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      remaining_q  <= remaining_d;
      digit_seen_q <= digit_seen_d;
    end
  end

  `ASSERT_PROP(a_data_only_in_data, (res_o.vld && res_o.kind == KIND_DATA) |-> (phase_q == PH_DATA), "data item outside data phase")
  `ASSERT_PROP(a_done_sticks, (phase_q == PH_DONE) |=> (phase_q == PH_DONE), "left done phase")
  `ASSERT_PROP(a_end_goes_done, (res_o.vld && res_o.kind != KIND_DATA) |=> (phase_q == PH_DONE), "end item without done")

endmodule

`default_nettype wire

/* rtl/chunked_body_decoder.sv */
// Chunked transfer-encoding body decoder.
// Input channel: one raw body byte per item on in_byte_i, qualified by
// in_valid_i and held off by in_stall_o. Output channel: out_valid_o with
// out_byte_o and kind_o, held off by out_stall_i. kind_o is data (byte in
// out_byte_o), terminal chunk, or malformed header (out_byte_o is zero).
// Header, line-end and trailer bytes produce no output item.
// An accepted byte is taken into the input register; the parser steps on it
// when the output register is free or draining, and its item is registered
// there. Throughput: one byte per cycle unless out_stall_i holds an item;
// the parser updates its state once per byte, so no byte waits on another.
// When out_stall_i holds a pending item, the input register keeps its byte
// and in_stall_o rises only once that register is full; nothing is dropped.
// Reset clears both registers and sets the parser to expect a size line
// with a zero count. After terminal or malformed, later bytes are consumed
// silently until the next reset.
`default_nettype none

module chunked_body_decoder
  import cbd_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o
);

`include "assert_macros.svh"

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q;
  logic [7:0]  out_byte_q;
  logic [1:0]  kind_q;
  logic        advance;
  logic        step;
  cbd_result_t res;

  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  cbd_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= res.vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= in_byte_i;
    end
    if (advance && res.vld) begin
      out_byte_q <= res.data;
      kind_q     <= res.kind;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = kind_q;

  `ASSERT_PROP(a_ctrl_byte_zero, (out_valid_o && kind_o != KIND_DATA) |-> (out_byte_o == 8'd0), "nonzero byte on end item")
  `ASSERT_NEVER(a_stall_empty, in_stall_o && !in_vld_q, "input stalled while empty")
  `ASSERT_PROP(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled item dropped")

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;
  import cbd_pkg::*;

  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1430;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS = 50;

  typedef enum int {
    END_TERMINAL,
    END_MALFORMED,
    END_SATURATED
  } stream_end_e;

  typedef struct {
    logic [7:0] data;
    logic [1:0] kind;
  } decoded_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;

  decoded_t pending_q[$];
  int       errors = 0;
  int       cycle_count = 0;
  int       sent_count = 0;
  int       hold_left = 0;
  bit       hold_req = 1'b0;
  bit       idle_en = 1'b1;

  phase_e               dec_phase = PH_LEAD;
  logic [COUNT_W-1:0]   dec_count = '0;
  logic                 dec_digit_seen = 1'b0;

  chunked_body_decoder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .kind_o     (kind_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(0, 99) < 10);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("result with none expected", {kind_o, out_byte_o}, 0);
      end else begin
        want = pending_q.pop_front();
        if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
        if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
      end
    end
  end

  function automatic int hex_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input int unsigned nib);
    if (nib < 10) return 8'("0" + nib);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
  endfunction

  task automatic expect_result(input logic [7:0] data, input logic [1:0] kind);
    decoded_t r;
    r.data = data;
    r.kind = kind;
    pending_q.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int d;
    d = hex_of(b);
    case (dec_phase)
      PH_TAIL_CR: begin
        if (b == CH_LF) begin
          if (!dec_digit_seen) begin
            dec_phase = PH_DONE;
            expect_result(8'h00, KIND_MALFORMED);
          end else if (dec_count == 0) begin
            dec_phase = PH_DONE;
            expect_result(8'h00, KIND_TERMINAL);
          end else begin
            dec_phase = PH_DATA;
          end
        end else begin
          dec_phase = (b == CH_CR) ? PH_TAIL_CR : PH_TAIL;
        end
      end
      PH_LEAD, PH_DIGITS: begin
        if (dec_phase == PH_LEAD && (b == CH_SPACE || b == CH_TAB)) begin
          dec_phase = PH_LEAD;
        end else if (d >= 0) begin
          dec_digit_seen = 1'b1;
          // saturate like strtoull
          if (64'(dec_count) > (64'(COUNT_MAX) - 64'(d)) / 16)
            dec_count = COUNT_MAX;
          else
            dec_count = COUNT_W'(64'(dec_count) * 16 + 64'(d));
          dec_phase = PH_DIGITS;
        end else begin
          dec_phase = (b == CH_CR) ? PH_TAIL_CR : PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (b == CH_CR) dec_phase = PH_TAIL_CR;
      end
      PH_DATA: begin
        dec_count = dec_count - 1'b1;
        if (dec_count == 0) dec_phase = PH_SKIP2;
        expect_result(b, KIND_DATA);
      end
      PH_SKIP2: dec_phase = PH_SKIP1;
      PH_SKIP1: begin
        dec_phase = PH_LEAD;
        dec_count = '0;
        dec_digit_seen = 1'b0;
      end
      default: dec_phase = PH_DONE;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    while (idle_en && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf;
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_hex(input int unsigned v);
    int n;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    for (int k = n - 1; k >= 0; k--) send_byte(hex_char((v >> (4 * k)) & 4'hf));
  endtask

  task automatic send_header(input int unsigned size);
    int unsigned nb;
    logic [7:0] j;
    logic [7:0] prev;
    repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte("0");
    send_hex(size);
    if ($urandom_range(0, 2) == 0) begin
      prev = 8'h00;
      nb = $urandom_range(1, 6);
      for (int i = 0; i < nb; i++) begin
        j = $urandom_range(0, 255);
        // keep the size intact and the line open
        if (i == 0 && hex_of(j) >= 0) j = ";";
        if (prev == CH_CR && j == CH_LF) j = "=";
        send_byte(j);
        prev = j;
      end
    end
    send_crlf();
  endtask

  task automatic send_chunk(input int unsigned size);
    send_header(size);
    repeat (size) send_byte($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      send_byte($urandom_range(0, 255));
      send_byte($urandom_range(0, 255));
    end else begin
      send_crlf();
    end
  endtask

  task automatic wait_drained;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_chunk;
    send_byte(CH_TAB);
    send_text(" 3");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CH_CR);
    send_crlf();
  endtask

  task automatic test_header_oddities;
    send_text("2;x");
    send_byte(CH_CR);
    send_crlf();
    send_byte(CH_LF);
    send_byte(8'h80);
    send_text("XY");
    send_text("1");
    send_byte(CH_LF);
    send_crlf();
    send_byte(8'h7f);
    send_crlf();
  endtask

  task automatic test_backpressure;
    idle_en = 1'b0;
    hold_req = 1'b1;
    send_chunk(48);
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_random_chunks;
    int target;
    int quiet_until;
    int unsigned sel;
    target = sent_count + RANDOM_ITEMS;
    quiet_until = sent_count + 400;
    idle_en = 1'b0;
    while (sent_count < target) begin
      if (sent_count >= quiet_until) idle_en = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 85) send_chunk($urandom_range(1, 8));
      else if (sel < 97) send_chunk($urandom_range(9, 40));
      else send_chunk($urandom_range(41, 120));
    end
    idle_en = 1'b1;
  endtask

  task automatic test_stream_end;
    stream_end_e pick;
    pick = stream_end_e'($urandom_range(0, 2));
    case (pick)
      END_TERMINAL: begin
        if ($urandom_range(0, 1)) send_text(" 0x1F;end");
        else send_text("000");
        send_crlf();
      end
      END_MALFORMED: begin
        case ($urandom_range(0, 3))
          0: send_text("+12");
          1: send_text("-5");
          2: send_text("g;ext");
          default: ;
        endcase
        send_crlf();
      end
      default: begin
        // oversized size clamps, then the tail is cut short
        send_byte(CH_TAB);
        send_text("1");
        repeat ($urandom_range(8, 12)) send_byte(hex_char($urandom_range(0, 15)));
        send_crlf();
        repeat (30) send_byte($urandom_range(0, 255));
      end
    endcase
    repeat (20) send_byte($urandom_range(0, 255));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_chunk();
    test_header_oddities();
    wait_drained();
    test_backpressure();
    test_random_chunks();
    wait_drained();
    test_stream_end();
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_q.size() != 0) report_mismatch("results never arrived", 0, pending_q.size());
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/cbd_pkg.sv
rtl/cbd_parser.sv
rtl/chunked_body_decoder.sv
dv/testbench.sv
